>>> rtl/core/polyline_proximity_hit_test_defines.svh
// Assertion macros for the polyline proximity hit test.
// Depends on nothing; taken in by the top level.
`ifndef POLYLINE_PROXIMITY_HIT_TEST_DEFINES_SVH
`define POLYLINE_PROXIMITY_HIT_TEST_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PPHT_HOLDS(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define PPHT_HOLDS_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/ppht_pkg.sv
// Shared constants, request codes and handshake structs of the polyline hit test.
// Depends on nothing.
package ppht_pkg;

   localparam int DEF_MAX_POINTS = 256;

   localparam int COORD_W   = 32;
   localparam int TOL_W     = 24;
   localparam int TOL2_W    = 2 * TOL_W;
   localparam int CNT_OUT_W = 9;
   localparam int REQ_W     = 2;

   // Segment arithmetic widths
   localparam int DIFF_W = COORD_W + 1;   // coordinate difference
   localparam int MOP_W  = DIFF_W + 1;    // multiplier operand
   localparam int PROD_W = 2 * MOP_W;     // multiplier product
   localparam int MAG_W  = 2 * COORD_W + 1; // squared sums, cross product magnitude
   localparam int HALF_W = DIFF_W;        // split point for wide products
   localparam int WIDE_W = 2 * MAG_W;     // square of a cross product

   localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd0;
   localparam logic [REQ_W-1:0] REQ_APPEND = 2'd1;
   localparam logic [REQ_W-1:0] REQ_PROX   = 2'd2;
   localparam logic [REQ_W-1:0] REQ_RECT   = 2'd3;

   typedef struct packed {
      logic start;
      logic le_mode;   // single point: hit on equality too
   } seg_cmd_type;

   typedef struct packed {
      logic done;
      logic hit;
   } seg_stat_type;

endpackage

>>> rtl/core/ppht_store.sv
// Point store: one write port, one registered read port.
// Depends on ppht_pkg.
module ppht_store #(
   parameter int MAX_POINTS = ppht_pkg::DEF_MAX_POINTS,
   parameter int ADR_W      = $clog2(MAX_POINTS)
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [ADR_W-1:0]                  wr_addr,
   input  logic [2*ppht_pkg::COORD_W-1:0]    wr_data,
   input  logic                              rd_en,
   input  logic [ADR_W-1:0]                  rd_addr,
   output logic [2*ppht_pkg::COORD_W-1:0]    rd_data
);
   import ppht_pkg::*;

   logic [2*COORD_W-1:0] mem [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

>>> rtl/core/ppht_seg.sv
// Segment distance test: exact squared-distance compare over a shared bank of
// four multipliers. Depends on ppht_pkg.
module ppht_seg (
   input  logic                                clock,
   input  logic                                reset,
   input  ppht_pkg::seg_cmd_type               cmd,
   input  logic signed [ppht_pkg::COORD_W-1:0] ax,
   input  logic signed [ppht_pkg::COORD_W-1:0] ay,
   input  logic signed [ppht_pkg::COORD_W-1:0] bx,
   input  logic signed [ppht_pkg::COORD_W-1:0] by,
   input  logic signed [ppht_pkg::COORD_W-1:0] px,
   input  logic signed [ppht_pkg::COORD_W-1:0] py,
   input  logic [ppht_pkg::TOL2_W-1:0]         tol2,
   output ppht_pkg::seg_stat_type              stat
);
   import ppht_pkg::*;

   localparam logic [2:0] SG_IDLE = 3'd0;
   localparam logic [2:0] SG_M1   = 3'd1;
   localparam logic [2:0] SG_M2   = 3'd2;
   localparam logic [2:0] SG_M3   = 3'd3;
   localparam logic [2:0] SG_SQ   = 3'd4;
   localparam logic [2:0] SG_RH   = 3'd5;
   localparam logic [2:0] SG_FIN  = 3'd6;
   localparam logic [2:0] SG_RES  = 3'd7;

   logic [2:0] state_ff, state_in;
   logic       le_ff;

   logic signed [DIFF_W-1:0] dx_ff, dy_ff, wx_ff, wy_ff, ex_ff, ey_ff;
   logic signed [MOP_W-1:0]  op_a [4];
   logic signed [MOP_W-1:0]  op_b [4];
   logic signed [PROD_W-1:0] pp_ff [4];

   logic signed [PROD_W-1:0] t_ff, cr_ff, cr_abs, sum01, sum23, diff23;
   logic [MAG_W-1:0]         den_ff, d2a_ff, d2b_ff, cr_mag, tol2_x;
   logic [WIDE_W-1:0]        c2_ff, rhs_ff, comb;

   function automatic logic signed [MOP_W-1:0] sx(input logic signed [DIFF_W-1:0] v);
      sx = {v[DIFF_W-1], v};
   endfunction

   assign cr_abs = cr_ff[PROD_W-1] ? -cr_ff : cr_ff;
   assign cr_mag = cr_abs[MAG_W-1:0];
   assign tol2_x = MAG_W'(tol2);

   assign sum01  = pp_ff[0] + pp_ff[1];
   assign sum23  = pp_ff[2] + pp_ff[3];
   assign diff23 = pp_ff[2] - pp_ff[3];

   // recombine four partial products: lo*lo + (lo*hi + hi*lo) << H + hi*hi << 2H
   assign comb = WIDE_W'($unsigned(pp_ff[0]))
               + ((WIDE_W'($unsigned(pp_ff[1])) + WIDE_W'($unsigned(pp_ff[2]))) << HALF_W)
               + (WIDE_W'($unsigned(pp_ff[3])) << (2 * HALF_W));

   // multiplier operand selection
   always_comb begin
      for (int k = 0; k < 4; k++) begin
         op_a[k] = '0;
         op_b[k] = '0;
      end
      unique case (state_ff)
         SG_M1: begin
            op_a[0] = sx(wx_ff); op_b[0] = sx(dx_ff);
            op_a[1] = sx(wy_ff); op_b[1] = sx(dy_ff);
            op_a[2] = sx(wx_ff); op_b[2] = sx(dy_ff);
            op_a[3] = sx(wy_ff); op_b[3] = sx(dx_ff);
         end
         SG_M2: begin
            op_a[0] = sx(dx_ff); op_b[0] = sx(dx_ff);
            op_a[1] = sx(dy_ff); op_b[1] = sx(dy_ff);
            op_a[2] = sx(wx_ff); op_b[2] = sx(wx_ff);
            op_a[3] = sx(wy_ff); op_b[3] = sx(wy_ff);
         end
         SG_M3: begin
            op_a[0] = sx(ex_ff); op_b[0] = sx(ex_ff);
            op_a[1] = sx(ey_ff); op_b[1] = sx(ey_ff);
         end
         SG_SQ: begin
            op_a[0] = MOP_W'(cr_mag[HALF_W-1:0]);     op_b[0] = MOP_W'(cr_mag[HALF_W-1:0]);
            op_a[1] = MOP_W'(cr_mag[HALF_W-1:0]);     op_b[1] = MOP_W'(cr_mag[MAG_W-1:HALF_W]);
            op_a[2] = MOP_W'(cr_mag[MAG_W-1:HALF_W]); op_b[2] = MOP_W'(cr_mag[HALF_W-1:0]);
            op_a[3] = MOP_W'(cr_mag[MAG_W-1:HALF_W]); op_b[3] = MOP_W'(cr_mag[MAG_W-1:HALF_W]);
         end
         SG_RH: begin
            op_a[0] = MOP_W'(tol2_x[HALF_W-1:0]);     op_b[0] = MOP_W'(den_ff[HALF_W-1:0]);
            op_a[1] = MOP_W'(tol2_x[HALF_W-1:0]);     op_b[1] = MOP_W'(den_ff[MAG_W-1:HALF_W]);
            op_a[2] = MOP_W'(tol2_x[MAG_W-1:HALF_W]); op_b[2] = MOP_W'(den_ff[HALF_W-1:0]);
            op_a[3] = MOP_W'(tol2_x[MAG_W-1:HALF_W]); op_b[3] = MOP_W'(den_ff[MAG_W-1:HALF_W]);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 4; k++) begin
         pp_ff[k] <= op_a[k] * op_b[k];
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SG_IDLE: if (cmd.start) state_in = SG_M1;
         SG_M1:   state_in = SG_M2;
         SG_M2:   state_in = SG_M3;
         SG_M3:   state_in = SG_SQ;
         SG_SQ:   state_in = SG_RH;
         SG_RH:   state_in = SG_FIN;
         SG_FIN:  state_in = SG_RES;
         SG_RES:  state_in = SG_IDLE;
         default: state_in = SG_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SG_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // latch differences and staged sums
   always_ff @(posedge clock) begin
      if (state_ff == SG_IDLE && cmd.start) begin
         dx_ff <= $signed({bx[COORD_W-1], bx}) - $signed({ax[COORD_W-1], ax});
         dy_ff <= $signed({by[COORD_W-1], by}) - $signed({ay[COORD_W-1], ay});
         wx_ff <= $signed({px[COORD_W-1], px}) - $signed({ax[COORD_W-1], ax});
         wy_ff <= $signed({py[COORD_W-1], py}) - $signed({ay[COORD_W-1], ay});
         ex_ff <= $signed({px[COORD_W-1], px}) - $signed({bx[COORD_W-1], bx});
         ey_ff <= $signed({py[COORD_W-1], py}) - $signed({by[COORD_W-1], by});
         le_ff <= cmd.le_mode;
      end
      if (state_ff == SG_M2) begin
         t_ff  <= sum01;
         cr_ff <= diff23;
      end
      if (state_ff == SG_M3) begin
         den_ff <= sum01[MAG_W-1:0];
         d2a_ff <= sum23[MAG_W-1:0];
      end
      if (state_ff == SG_SQ) begin
         d2b_ff <= sum01[MAG_W-1:0];
      end
      if (state_ff == SG_RH) begin
         c2_ff <= comb;
      end
      if (state_ff == SG_FIN) begin
         rhs_ff <= comb;
      end
   end

   // projection before the start, past the end, or onto the interior
   always_comb begin
      stat.done = (state_ff == SG_RES);
      if (t_ff[PROD_W-1] || t_ff == '0) begin
         stat.hit = le_ff ? (d2a_ff <= tol2_x) : (d2a_ff < tol2_x);
      end else if (t_ff >= $signed(PROD_W'(den_ff))) begin
         stat.hit = d2b_ff < tol2_x;
      end else begin
         stat.hit = c2_ff < rhs_ff;
      end
   end

endmodule

>>> rtl/core/ppht_div.sv
// Centroid divider: two restoring lanes, one quotient bit per cycle.
// Depends on ppht_pkg.
module ppht_div #(
   parameter int SUM_W = 40,
   parameter int CNT_W = 9
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [SUM_W-1:0]             sum_x,
   input  logic signed [SUM_W-1:0]             sum_y,
   input  logic [CNT_W-1:0]                    divisor,
   output logic                                busy,
   output logic signed [ppht_pkg::COORD_W-1:0] quot_x,
   output logic signed [ppht_pkg::COORD_W-1:0] quot_y
);
   import ppht_pkg::*;

   localparam int ITER_W = $clog2(SUM_W + 1);

   logic              busy_ff;
   logic [ITER_W-1:0] iter_ff;
   logic [SUM_W-1:0]  shx_ff, shy_ff, qx_full, qy_full;
   logic [CNT_W-1:0]  remx_ff, remy_ff, div_ff;
   logic              negx_ff, negy_ff;
   logic [CNT_W:0]    rtx, rty;
   logic              gex, gey;
   logic [CNT_W:0]    subx, suby;

   assign rtx  = {remx_ff, shx_ff[SUM_W-1]};
   assign rty  = {remy_ff, shy_ff[SUM_W-1]};
   assign gex  = rtx >= {1'b0, div_ff};
   assign gey  = rty >= {1'b0, div_ff};
   assign subx = rtx - {1'b0, div_ff};
   assign suby = rty - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && iter_ff == ITER_W'(1)) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         iter_ff <= ITER_W'(SUM_W);
         shx_ff  <= sum_x[SUM_W-1] ? SUM_W'(-sum_x) : SUM_W'(sum_x);
         shy_ff  <= sum_y[SUM_W-1] ? SUM_W'(-sum_y) : SUM_W'(sum_y);
         negx_ff <= sum_x[SUM_W-1];
         negy_ff <= sum_y[SUM_W-1];
         remx_ff <= '0;
         remy_ff <= '0;
         div_ff  <= divisor;
      end else if (busy_ff) begin
         iter_ff <= iter_ff - ITER_W'(1);
         remx_ff <= gex ? subx[CNT_W-1:0] : rtx[CNT_W-1:0];
         remy_ff <= gey ? suby[CNT_W-1:0] : rty[CNT_W-1:0];
         shx_ff  <= {shx_ff[SUM_W-2:0], gex};
         shy_ff  <= {shy_ff[SUM_W-2:0], gey};
      end
   end

   // truncate toward zero: negate the magnitude quotient for a negative sum
   assign qx_full = negx_ff ? (~shx_ff + SUM_W'(1)) : shx_ff;
   assign qy_full = negy_ff ? (~shy_ff + SUM_W'(1)) : shy_ff;
   assign quot_x  = qx_full[COORD_W-1:0];
   assign quot_y  = qy_full[COORD_W-1:0];
   assign busy    = busy_ff;

endmodule

>>> rtl/core/polyline_proximity_hit_test.sv
// Polyline proximity hit test, top level: request sequencer, summary state,
// result register. Depends on ppht_pkg, ppht_store, ppht_seg, ppht_div and the defines header.
//
// Keeps a polyline of up to MAX_POINTS Q24.8 points in a synchronous point
// memory, with its bounding box, coordinate sums and first point in registers.
// Clear and append words complete when they are taken; an append to a full store is
// dropped and sets the dropped flag until the next clear. A proximity query
// walks the segments in memory order: each segment costs one memory read, a
// start step and a run of the shared four-multiplier segment unit, and the walk
// stops at the first hit (a single stored point is one pass). Distances are
// compared as exact squared values, so there is no rounding. Every query on a
// non-empty polyline also needs the centroid from the bit-serial divider, run
// alongside the walk; a rectangle query waits for it in the finish state.
// One word is in flight at a time; req_ready is high whenever the sequencer is
// idle, and a finished result waits in the output register so the next word
// can be taken before the previous result is drained. There is no clearing
// pass: the point memory holds no reset value and only entries below the
// point count are ever read.
`include "polyline_proximity_hit_test_defines.svh"

module polyline_proximity_hit_test #(
   parameter int MAX_POINTS = ppht_pkg::DEF_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ppht_pkg::REQ_W-1:0]          req_type,
   input  logic signed [ppht_pkg::COORD_W-1:0] req_x,
   input  logic signed [ppht_pkg::COORD_W-1:0] req_y,
   input  logic signed [ppht_pkg::COORD_W-1:0] req_x_hi,
   input  logic signed [ppht_pkg::COORD_W-1:0] req_y_hi,
   input  logic [ppht_pkg::TOL_W-1:0]          req_tolerance,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_hit,
   output logic                                rsp_overlaps,
   output logic [ppht_pkg::CNT_OUT_W-1:0]      rsp_point_count,
   output logic signed [ppht_pkg::COORD_W-1:0] rsp_first_x,
   output logic signed [ppht_pkg::COORD_W-1:0] rsp_first_y,
   output logic signed [ppht_pkg::COORD_W-1:0] rsp_center_x,
   output logic signed [ppht_pkg::COORD_W-1:0] rsp_center_y,
   output logic                                rsp_points_dropped
);
   import ppht_pkg::*;

   localparam int ADR_W = $clog2(MAX_POINTS);
   localparam int CNT_W = $clog2(MAX_POINTS + 1);
   localparam int SUM_W = COORD_W + ADR_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_RD   = 3'd1;
   localparam logic [2:0] ST_SEG  = 3'd2;
   localparam logic [2:0] ST_WAIT = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   logic [2:0] state_ff, state_in;

   // summary state
   logic [CNT_W-1:0]          count_ff;
   logic                      box_valid_ff, ovf_ff;
   logic signed [COORD_W-1:0] bxmin_ff, bymin_ff, bxmax_ff, bymax_ff;
   logic signed [COORD_W-1:0] firstx_ff, firsty_ff;
   logic signed [SUM_W-1:0]   sumx_ff, sumy_ff;

   // query context
   logic [REQ_W-1:0]          qtype_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff, pxh_ff, pyh_ff, ax_ff, ay_ff;
   logic [TOL2_W-1:0]         tol2_ff, tol2_in;
   logic [CNT_W-1:0]          idx_ff;
   logic                      hit_ff;

   // result register
   logic                      rsp_valid_ff, hit_out_ff, ov_out_ff, drop_out_ff;
   logic [CNT_OUT_W-1:0]      cnt_out_ff;
   logic signed [COORD_W-1:0] fx_out_ff, fy_out_ff, cx_out_ff, cy_out_ff;

   logic                      accept, store_full, last_seg, div_busy, load_rsp, ov_calc;
   logic [2*COORD_W-1:0]      rd_data;
   logic signed [COORD_W-1:0] b_x, b_y, quot_x, quot_y;
   seg_cmd_type               seg_cmd;
   seg_stat_type              seg_stat;

   assign accept     = req_valid && req_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign store_full = (count_ff == CNT_W'(MAX_POINTS));
   assign last_seg   = (idx_ff == count_ff - CNT_W'(1));
   assign b_x        = rd_data[COORD_W-1:0];
   assign b_y        = rd_data[2*COORD_W-1:COORD_W];
   assign tol2_in    = TOL2_W'(req_tolerance) * TOL2_W'(req_tolerance);

   assign seg_cmd.start   = (state_ff == ST_SEG);
   assign seg_cmd.le_mode = (count_ff == CNT_W'(1));

   // drain into the result register once the centroid is ready and the slot is free
   assign load_rsp = (state_ff == ST_FIN) && !div_busy && (!rsp_valid_ff || rsp_ready);

   ppht_store #(
      .MAX_POINTS (MAX_POINTS),
      .ADR_W      (ADR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept && req_type == REQ_APPEND && !store_full),
      .wr_addr (count_ff[ADR_W-1:0]),
      .wr_data ({req_y, req_x}),
      .rd_en   (state_ff == ST_RD),
      .rd_addr (idx_ff[ADR_W-1:0]),
      .rd_data (rd_data)
   );

   ppht_seg u_seg (
      .clock (clock),
      .reset (reset),
      .cmd   (seg_cmd),
      .ax    (ax_ff),
      .ay    (ay_ff),
      .bx    (b_x),
      .by    (b_y),
      .px    (px_ff),
      .py    (py_ff),
      .tol2  (tol2_ff),
      .stat  (seg_stat)
   );

   ppht_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div (
      .clock   (clock),
      .reset   (reset),
      .start   (accept && (req_type == REQ_PROX || req_type == REQ_RECT) && count_ff != '0),
      .sum_x   (sumx_ff),
      .sum_y   (sumy_ff),
      .divisor (count_ff),
      .busy    (div_busy),
      .quot_x  (quot_x),
      .quot_y  (quot_y)
   );

   // sequencer: walk segments for a proximity query, then wait for the result slot
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_type == REQ_PROX) begin
               state_in = (count_ff == '0) ? ST_FIN : ST_RD;
            end else if (accept && req_type == REQ_RECT) begin
               state_in = ST_FIN;
            end
         end
         ST_RD:   state_in = ST_SEG;
         ST_SEG:  state_in = ST_WAIT;
         ST_WAIT: begin
            if (seg_stat.done) begin
               state_in = (seg_stat.hit || last_seg) ? ST_FIN : ST_RD;
            end
         end
         ST_FIN:  if (load_rsp) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // summary state: clear and append
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         box_valid_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
      end else if (accept && req_type == REQ_CLEAR) begin
         count_ff     <= '0;
         box_valid_ff <= 1'b0;
         ovf_ff       <= 1'b0;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
      end else if (accept && req_type == REQ_APPEND) begin
         if (store_full) begin
            ovf_ff <= 1'b1;
         end else begin
            count_ff     <= count_ff + CNT_W'(1);
            box_valid_ff <= 1'b1;
            sumx_ff      <= sumx_ff + SUM_W'(req_x);
            sumy_ff      <= sumy_ff + SUM_W'(req_y);
         end
      end
   end

   // box and first point carry no reset: read only once a point is held
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_APPEND && !store_full) begin
         if (count_ff == '0) begin
            firstx_ff <= req_x;
            firsty_ff <= req_y;
         end
         if (!box_valid_ff || req_x < bxmin_ff) bxmin_ff <= req_x;
         if (!box_valid_ff || req_y < bymin_ff) bymin_ff <= req_y;
         if (!box_valid_ff || req_x > bxmax_ff) bxmax_ff <= req_x;
         if (!box_valid_ff || req_y > bymax_ff) bymax_ff <= req_y;
      end
   end

   // query context and walk position
   always_ff @(posedge clock) begin
      if (accept) begin
         qtype_ff <= req_type;
         px_ff    <= req_x;
         py_ff    <= req_y;
         pxh_ff   <= req_x_hi;
         pyh_ff   <= req_y_hi;
         tol2_ff  <= tol2_in;
         ax_ff    <= firstx_ff;
         ay_ff    <= firsty_ff;
         idx_ff   <= (count_ff == CNT_W'(1)) ? '0 : CNT_W'(1);
      end else if (state_ff == ST_WAIT && seg_stat.done) begin
         // advance: this segment's far end opens the next one
         ax_ff  <= b_x;
         ay_ff  <= b_y;
         idx_ff <= idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff <= 1'b0;
      end else if (accept) begin
         hit_ff <= 1'b0;
      end else if (state_ff == ST_WAIT && seg_stat.done && seg_stat.hit) begin
         hit_ff <= 1'b1;
      end
   end

   // closed box intersection; an inverted rectangle never meets it
   assign ov_calc = box_valid_ff && px_ff <= pxh_ff && py_ff <= pyh_ff
                 && bxmin_ff <= pxh_ff && px_ff <= bxmax_ff
                 && bymin_ff <= pyh_ff && py_ff <= bymax_ff;

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         hit_out_ff  <= (qtype_ff == REQ_PROX) && hit_ff;
         ov_out_ff   <= (qtype_ff == REQ_RECT) && ov_calc;
         cnt_out_ff  <= CNT_OUT_W'(count_ff);
         drop_out_ff <= ovf_ff;
         if (count_ff == '0) begin
            fx_out_ff <= '0;
            fy_out_ff <= '0;
            cx_out_ff <= '0;
            cy_out_ff <= '0;
         end else begin
            fx_out_ff <= firstx_ff;
            fy_out_ff <= firsty_ff;
            cx_out_ff <= quot_x;
            cy_out_ff <= quot_y;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_hit            = hit_out_ff;
   assign rsp_overlaps       = ov_out_ff;
   assign rsp_point_count    = cnt_out_ff;
   assign rsp_first_x        = fx_out_ff;
   assign rsp_first_y        = fy_out_ff;
   assign rsp_center_x       = cx_out_ff;
   assign rsp_center_y       = cy_out_ff;
   assign rsp_points_dropped = drop_out_ff;

   `PPHT_HOLDS_NEXT(a_full_append_flags, clock, reset, accept && req_type == REQ_APPEND && store_full, ovf_ff, "append to a full store did not set the dropped flag")
   `PPHT_HOLDS(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == ST_FIN, "result raised outside the finish state")
   `PPHT_HOLDS(a_seg_done_in_walk, clock, reset, seg_stat.done, state_ff == ST_WAIT, "segment unit finished outside the walk")
   `PPHT_HOLDS(a_accept_div_idle, clock, reset, accept, !div_busy, "word taken while the divider was busy")

endmodule
